FILE: design/psllr_pkg.sv
// Shared types, widths and constants of the Poisson scan log likelihood block.
// Used by every design file; no dependencies of its own.
package psllr_pkg;

  localparam int CASES_W   = 24;
  localparam int MEAS_W    = 40;
  localparam int SET_W     = 2;
  localparam int OUT_W     = 48;
  localparam int MAX_SETS  = 4;

  localparam int LOG_Q     = 28;
  localparam int K_W       = 6;
  localparam int LOG_W     = K_W + LOG_Q;
  localparam int MANT_W    = 31;
  localparam int ROUNDS    = LOG_Q;
  localparam int LOG_LAT   = ROUNDS + 2;
  localparam int SUM_W     = 64;

  localparam logic [LOG_Q-1:0] LN2_Q28 = 28'd186065279;

  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CASES_0   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MEASURE_0 = 3'd4;

  localparam logic signed [SUM_W-1:0] OUT_MAX_W = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] OUT_MIN_W = -64'sh0000_8000_0000_0000;
  localparam logic [OUT_W-1:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic bad;
    logic use_in;
    logic use_out;
    logic use_null;
  } flags_t;

  typedef struct packed {
    flags_t              flags;
    logic [CASES_W-1:0]  n;
    logic [CASES_W-1:0]  nout;
    logic [CASES_W-1:0]  ntot;
    logic [MEAS_W-1:0]   u;
    logic [MEAS_W-1:0]   uout;
    logic [MEAS_W-1:0]   utot;
  } qitem_t;

  function automatic logic [OUT_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    if (v > OUT_MAX_W) begin
      return OUT_MAX;
    end else if (v < OUT_MIN_W) begin
      return OUT_MIN;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

FILE: design/psllr_if.sv
// Valid/ready channel interfaces for scan windows and their results.
// Depends on psllr_pkg for the field widths.
interface psllr_win_if import psllr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CASES_W-1:0]  window_cases;
  logic [MEAS_W-1:0]   window_expected;
  logic [SET_W-1:0]    set_index;

  modport source(output valid, window_cases, window_expected, set_index, input ready);
  modport sink(input valid, window_cases, window_expected, set_index, output ready);
endinterface

interface psllr_res_if import psllr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  log_likelihood;
  logic signed [OUT_W-1:0]  likelihood_ratio;
  logic                     invalid;

  modport source(output valid, log_likelihood, likelihood_ratio, invalid, input ready);
  modport sink(input valid, log_likelihood, likelihood_ratio, invalid, output ready);
endinterface

FILE: design/poisson_scan_log_likelihood_ratio.sv
// Poisson scan window log likelihood and likelihood ratio evaluator.
// Depends on psllr_pkg, the channel interfaces, psllr_front, psllr_queue, psllr_back.
//
// Windows arrive on the win channel (observed cases, expected cases in
// Q(40-FRAC_BITS).FRAC_BITS, data set index) and results leave on the res channel
// (log likelihood, likelihood ratio, invalid flag), both valid/ready.
// The totals of each data set are written over the APB port at byte
// address 8*i, cases at registers 0 to 3 and expected totals at 4 to 7;
// the user must write them only while no window is in flight; the
// block does not enforce this. One window is accepted per cycle while
// the queue is not full. A window accepted into an empty queue leaves it
// for 30 logarithm stages (input register, normalization and one squaring
// per fraction bit), then three term stages and two stages for summing
// and saturation.
// When res is stalled the pipeline holds, the queue fills, and win.ready
// drops once the queue holds QUEUE_DEPTH windows.
// Reset clears the totals, the queue and all pipeline valid bits.
module poisson_scan_log_likelihood_ratio import psllr_pkg::*; #(
  parameter int NUM_SETS    = 4,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  psllr_win_if.sink          win,
  psllr_res_if.source        res
);

  logic [CASES_W-1:0]   total_cases [MAX_SETS];
  logic [MEAS_W-1:0]    total_measure [MAX_SETS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic                 q_full, q_push, q_pop, q_valid;
  qitem_t               push_item, head_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1 -: REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;

  for (genvar s = 0; s < MAX_SETS; s++) begin : g_set
    if (s < NUM_SETS) begin : g_used
      always_ff @(posedge clk) begin
        if (rst) begin
          total_cases[s]   <= '0;
          total_measure[s] <= '0;
        end else if (wr_en) begin
          if (reg_idx == REG_CASES_0 + REG_IDX_W'(s)) begin
            total_cases[s] <= pwdata[CASES_W-1:0];
          end
          if (reg_idx == REG_MEASURE_0 + REG_IDX_W'(s)) begin
            total_measure[s] <= pwdata[MEAS_W-1:0];
          end
        end
      end
    end else begin : g_unused
      assign total_cases[s]   = '0;
      assign total_measure[s] = '0;
    end
  end

  always_comb begin
    if (reg_idx < REG_MEASURE_0) begin
      prdata = CFG_DW'(total_cases[reg_idx[SET_W-1:0]]);
    end else begin
      prdata = CFG_DW'(total_measure[reg_idx[SET_W-1:0]]);
    end
  end

  psllr_front #(.NUM_SETS(NUM_SETS)) u_front (
    .win(win),
    .total_cases(total_cases),
    .total_measure(total_measure),
    .q_full(q_full),
    .q_push(q_push),
    .q_item(push_item)
  );

  psllr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_item(push_item),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_valid),
    .head_item(head_item)
  );

  psllr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_item(head_item),
    .q_pop(q_pop),
    .res(res)
  );

endmodule

FILE: design/psllr_front.sv
// Front end: accepts windows, looks up the set totals and classifies operands.
// Depends on psllr_pkg and psllr_win_if.
module psllr_front import psllr_pkg::*; #(
  parameter int NUM_SETS = 4
) (
  psllr_win_if.sink           win,
  input  logic [CASES_W-1:0]  total_cases [MAX_SETS],
  input  logic [MEAS_W-1:0]   total_measure [MAX_SETS],
  input  logic                q_full,
  output logic                q_push,
  output qitem_t              q_item
);

  logic [CASES_W-1:0] n, ntot;
  logic [MEAS_W-1:0]  u, utot;
  logic               set_ok;

  assign n      = win.window_cases;
  assign u      = win.window_expected;
  assign ntot   = total_cases[win.set_index];
  assign utot   = total_measure[win.set_index];
  assign set_ok = int'(win.set_index) < NUM_SETS;

  always_comb begin
    q_item.n              = n;
    q_item.u              = u;
    q_item.ntot           = ntot;
    q_item.utot           = utot;
    q_item.nout           = ntot - n;
    q_item.uout           = utot - u;
    q_item.flags.use_in   = n != '0;
    q_item.flags.use_out  = n != ntot;
    q_item.flags.use_null = ntot != '0;
    q_item.flags.bad      = !set_ok || (n > ntot) || ((n != '0) && (u == '0)) ||
                            ((n < ntot) && (u >= utot)) ||
                            ((ntot != '0) && (utot == '0));
  end

  assign win.ready = !q_full;
  assign q_push    = win.valid && !q_full;

endmodule

FILE: design/psllr_queue.sv
// Short queue of classified windows between the front end and the pipeline.
// Depends on psllr_pkg.
module psllr_queue import psllr_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qitem_t  push_item,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output qitem_t  head_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qitem_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_item  = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/psllr_log2.sv
// Pipelined base-2 logarithm in Q.28: normalize, then one squaring per stage.
// Depends on psllr_pkg.
module psllr_log2 import psllr_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [MEAS_W-1:0]  x,
  output logic [LOG_W-1:0]   y
);

  logic [K_W-1:0]     k_c, k1;
  logic [MEAS_W-1:0]  x1, x_al;
  logic [MANT_W-1:0]  m_q [ROUNDS+1];
  logic [K_W-1:0]     k_q [ROUNDS+1];
  logic [ROUNDS-1:0]  frac_q [ROUNDS];

  always_comb begin
    k_c = '0;
    for (int i = 0; i < MEAS_W; i++) begin
      if (x[i]) begin
        k_c = K_W'(i);
      end
    end
  end

  assign x_al = x1 << (K_W'(MEAS_W - 1) - k1);

  always_ff @(posedge clk) begin
    if (en) begin
      x1     <= x;
      k1     <= k_c;
      m_q[0] <= x_al[MEAS_W-1 -: MANT_W];
      k_q[0] <= k1;
    end
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     m2;
    logic [ROUNDS-1:0]   fin;

    assign sq = m_q[r] * m_q[r];
    assign m2 = sq[2*MANT_W-1 -: MANT_W+1];
    if (r == 0) begin : g_first
      assign fin = '0;
    end else begin : g_next
      assign fin = frac_q[r-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_q[r+1]  <= m2[MANT_W] ? m2[MANT_W:1] : m2[MANT_W-1:0];
        frac_q[r] <= {fin[ROUNDS-2:0], m2[MANT_W]};
        k_q[r+1]  <= k_q[r];
      end
    end
  end

  assign y = {k_q[ROUNDS], frac_q[ROUNDS-1]};

endmodule

FILE: design/psllr_term.sv
// One term c*ln(a/b) from the two logarithms, in three stages.
// Depends on psllr_pkg.
module psllr_term import psllr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [LOG_W-1:0]         la,
  input  logic [LOG_W-1:0]         lb,
  input  logic [CASES_W-1:0]       c,
  output logic signed [SUM_W-1:0]  term
);

  localparam int D_W = LOG_W + 2;
  localparam int L_W = D_W - 1;
  localparam int SH  = LOG_Q - FRAC_BITS;
  localparam logic signed [D_W-1:0] OFFS = D_W'(FRAC_BITS) <<< LOG_Q;

  logic signed [D_W-1:0] d;
  logic [L_W-1:0]        mag1, l2;
  logic                  neg1, neg2;
  logic [CASES_W-1:0]    c1, c2;
  logic [SUM_W-1:0]      p2, p3, t3;

  assign d  = $signed({2'b00, la}) - $signed({2'b00, lb}) + OFFS;
  assign p2 = SUM_W'(mag1) * SUM_W'(LN2_Q28) + (SUM_W'(1) << (LOG_Q - 1));
  assign p3 = SUM_W'(c2) * SUM_W'(l2) + (SUM_W'(1) << (SH - 1));
  assign t3 = p3 >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= d[D_W-1];
      mag1 <= d[D_W-1] ? L_W'(-d) : L_W'(d);
      c1   <= c;
      neg2 <= neg1;
      l2   <= L_W'(p2 >> LOG_Q);
      c2   <= c1;
      term <= neg2 ? -$signed(t3) : $signed(t3);
    end
  end

endmodule

FILE: design/psllr_back.sv
// Back end: six logarithm pipelines, three term units, sum and saturation.
// Depends on psllr_pkg, psllr_res_if, psllr_log2 and psllr_term.
module psllr_back import psllr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  qitem_t      q_item,
  output logic        q_pop,
  psllr_res_if.source res
);

  localparam int DEPTH_ALL = LOG_LAT + 5;
  localparam int FL_LEN    = LOG_LAT + 3;

  logic [DEPTH_ALL-1:0]    vld;
  logic                    en;
  logic [LOG_W-1:0]        lg_n, lg_u, lg_nout, lg_uout, lg_ntot, lg_utot;
  logic [CASES_W-1:0]      cin_q [LOG_LAT];
  logic [CASES_W-1:0]      cout_q [LOG_LAT];
  logic [CASES_W-1:0]      cnull_q [LOG_LAT];
  flags_t                  fl_q [FL_LEN];
  flags_t                  fl4;
  logic signed [SUM_W-1:0] t_in, t_out, t_null, ll4, null4, ratio;
  logic [OUT_W-1:0]        ll_out, r_out;
  logic                    inv_out;

  assign en    = !vld[DEPTH_ALL-1] || res.ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH_ALL-2:0], q_valid};
    end
  end

  psllr_log2 u_lg_n    (.clk(clk), .en(en), .x(MEAS_W'(q_item.n)),    .y(lg_n));
  psllr_log2 u_lg_u    (.clk(clk), .en(en), .x(q_item.u),             .y(lg_u));
  psllr_log2 u_lg_nout (.clk(clk), .en(en), .x(MEAS_W'(q_item.nout)), .y(lg_nout));
  psllr_log2 u_lg_uout (.clk(clk), .en(en), .x(q_item.uout),          .y(lg_uout));
  psllr_log2 u_lg_ntot (.clk(clk), .en(en), .x(MEAS_W'(q_item.ntot)), .y(lg_ntot));
  psllr_log2 u_lg_utot (.clk(clk), .en(en), .x(q_item.utot),          .y(lg_utot));

  always_ff @(posedge clk) begin
    if (en) begin
      cin_q[0]   <= q_item.n;
      cout_q[0]  <= q_item.nout;
      cnull_q[0] <= q_item.ntot;
      fl_q[0]    <= q_item.flags;
      for (int i = 1; i < LOG_LAT; i++) begin
        cin_q[i]   <= cin_q[i-1];
        cout_q[i]  <= cout_q[i-1];
        cnull_q[i] <= cnull_q[i-1];
      end
      for (int i = 1; i < FL_LEN; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
    end
  end

  psllr_term #(.FRAC_BITS(FRAC_BITS)) u_t_in (
    .clk(clk), .en(en), .la(lg_n), .lb(lg_u), .c(cin_q[LOG_LAT-1]), .term(t_in)
  );
  psllr_term #(.FRAC_BITS(FRAC_BITS)) u_t_out (
    .clk(clk), .en(en), .la(lg_nout), .lb(lg_uout), .c(cout_q[LOG_LAT-1]), .term(t_out)
  );
  psllr_term #(.FRAC_BITS(FRAC_BITS)) u_t_null (
    .clk(clk), .en(en), .la(lg_ntot), .lb(lg_utot), .c(cnull_q[LOG_LAT-1]), .term(t_null)
  );

  assign ratio = ll4 - null4;

  always_ff @(posedge clk) begin
    if (en) begin
      fl4     <= fl_q[FL_LEN-1];
      ll4     <= (fl_q[FL_LEN-1].use_in ? t_in : '0) +
                 (fl_q[FL_LEN-1].use_out ? t_out : '0);
      null4   <= fl_q[FL_LEN-1].use_null ? t_null : '0;
      inv_out <= fl4.bad;
      ll_out  <= fl4.bad ? OUT_MIN : sat48(ll4);
      r_out   <= fl4.bad ? OUT_MIN : sat48(ratio);
    end
  end

  assign res.valid            = vld[DEPTH_ALL-1];
  assign res.log_likelihood   = ll_out;
  assign res.likelihood_ratio = r_out;
  assign res.invalid          = inv_out;

endmodule

FILE: bench/poisson_scan_log_likelihood_ratio_tb.sv
// Testbench of the Poisson scan log likelihood ratio block: directed table, then random windows.
// Depends on psllr_pkg, the channel interfaces in psllr_if.sv and the block's RTL.
`timescale 1ns / 100ps

module poisson_scan_log_likelihood_ratio_tb;
  import psllr_pkg::*;

  localparam int SETS = 4;
  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT = 2000000;
  localparam longint SCORE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SCORE_MIN = -64'sh0000_8000_0000_0000;
  localparam logic [CASES_W-1:0] CASES_TOP = '1;
  localparam logic [MEAS_W-1:0] MEAS_TOP = '1;

  typedef struct {
    logic signed [OUT_W-1:0] ll;
    logic signed [OUT_W-1:0] lr;
    logic                    inv;
  } score_t;

  typedef struct {
    logic [CASES_W-1:0] n;
    logic [MEAS_W-1:0]  u;
    logic [SET_W-1:0]   s;
    bit                 typed;
    score_t             want;
  } window_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  psllr_win_if win ();
  psllr_res_if res ();

  poisson_scan_log_likelihood_ratio i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .win(win.sink), .res(res.source)
  );

  logic [CASES_W-1:0] set_cases [SETS];
  logic [MEAS_W-1:0]  set_measure [SETS];
  score_t             pending_scores [$];
  int                 errors = 0;
  int                 windows_sent = 0;
  int                 scores_seen = 0;
  int                 invalid_seen = 0;
  int                 cycles = 0;
  bit                 no_idle = 1'b0;
  bit                 hold_go = 1'b0;
  bit                 hold_done = 1'b0;
  int                 hold_left = 0;

  const score_t ZERO_SCORE = '{ll: '0, lr: '0, inv: 1'b0};
  const score_t BAD_SCORE = '{ll: OUT_MIN, lr: OUT_MIN, inv: 1'b1};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint unsigned log2_fixed(input longint unsigned x);
    int k;
    longint unsigned m;
    longint unsigned acc;
    k = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
    acc = longint'(k) << LOG_Q;
    for (int i = LOG_Q - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        acc = acc | (64'd1 << i);
      end
    end
    return acc;
  endfunction

  function automatic longint weighted_ln(input longint unsigned c, input longint unsigned a,
                                         input longint unsigned b);
    longint d;
    longint unsigned mag;
    longint unsigned l;
    longint unsigned t;
    d = longint'(log2_fixed(a)) - longint'(log2_fixed(b)) + (longint'(FRAC) << LOG_Q);
    mag = (d < 0) ? longint'(-d) : d;
    l = (mag * 64'd186065279 + (64'd1 << (LOG_Q - 1))) >> LOG_Q;
    t = (c * l + (64'd1 << (LOG_Q - FRAC - 1))) >> (LOG_Q - FRAC);
    return (d < 0) ? -longint'(t) : longint'(t);
  endfunction

  function automatic logic [OUT_W-1:0] clamp48(input longint v);
    if (v > SCORE_MAX) return OUT_MAX;
    if (v < SCORE_MIN) return OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  function automatic score_t window_score(input logic [CASES_W-1:0] n,
                                          input logic [MEAS_W-1:0] u,
                                          input logic [SET_W-1:0] s);
    longint unsigned nn;
    longint unsigned uu;
    longint unsigned tn;
    longint unsigned tu;
    longint ll;
    longint null_term;
    score_t r;
    nn = n;
    uu = u;
    tn = set_cases[s];
    tu = set_measure[s];
    ll = 0;
    null_term = 0;
    if (nn > tn || (nn > 0 && uu == 0) || (nn < tn && uu >= tu) || (tn > 0 && tu == 0)) begin
      return BAD_SCORE;
    end
    if (nn != 0) ll += weighted_ln(nn, nn, uu);
    if (nn != tn) ll += weighted_ln(tn - nn, tn - nn, tu - uu);
    if (tn != 0) null_term = weighted_ln(tn, tn, tu);
    r.ll = clamp48(ll);
    r.lr = clamp48(ll - null_term);
    r.inv = 1'b0;
    return r;
  endfunction

  function automatic logic [MEAS_W-1:0] rand40();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    return t[MEAS_W-1:0];
  endfunction

  task automatic reg_write(input int idx, input logic [CFG_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < SETS) set_cases[idx] = val[CASES_W-1:0];
    else set_measure[idx - SETS] = val[MEAS_W-1:0];
  endtask

  task automatic load_totals(input logic [CASES_W-1:0] c [SETS],
                             input logic [MEAS_W-1:0] m [SETS]);
    for (int i = 0; i < SETS; i++) reg_write(i, CFG_DW'(c[i]));
    for (int i = 0; i < SETS; i++) reg_write(SETS + i, CFG_DW'(m[i]));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_window(input window_row_t row);
    while (!no_idle && $urandom_range(99) < 24) begin
      win.valid <= 1'b0;
      @(posedge clk);
    end
    win.valid <= 1'b1;
    win.window_cases <= row.n;
    win.window_expected <= row.u;
    win.set_index <= row.s;
    do @(posedge clk); while (!win.ready);
    pending_scores.insert(pending_scores.size(),
                          row.typed ? row.want : window_score(row.n, row.u, row.s));
    windows_sent++;
  endtask

  task automatic wait_idle();
    win.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [MEAS_W-1:0] MAX_TOP_U(input longint unsigned tu);
    return (tu == MEAS_TOP) ? MEAS_TOP : MEAS_W'(tu + 1 + rand40() % (MEAS_TOP - tu));
  endfunction

  function automatic window_row_t random_window();
    window_row_t w;
    logic [SET_W-1:0] s;
    longint unsigned tn;
    longint unsigned tu;
    int pick;
    s = SET_W'($urandom_range(SETS - 1));
    tn = set_cases[s];
    tu = set_measure[s];
    pick = $urandom_range(99);
    w.s = s;
    w.typed = 1'b0;
    w.want = ZERO_SCORE;
    w.n = (tn == 0) ? '0 : CASES_W'(longint'($urandom()) % (tn + 1));
    w.u = (tu <= 1) ? MEAS_W'(tu) : MEAS_W'(1 + rand40() % (tu - 1));
    if (pick < 8) begin
      w.n = CASES_W'($urandom());
      w.u = rand40();
    end else if (pick < 15) begin
      w.n = '0;
    end else if (pick < 22) begin
      w.n = CASES_W'(tn);
    end else if (pick < 25) begin
      w.u = '0;
    end else if (pick < 28) begin
      w.u = ($urandom_range(1)) ? MEAS_W'(tu) : MAX_TOP_U(tu);
    end else if (pick < 30) begin
      w.n = CASES_W'(tn + 1);
    end
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      res.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      res.ready <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk) begin
    score_t want;
    if (!rst && res.valid && res.ready) begin
      scores_seen++;
      if (pending_scores.size() == 0) begin
        $error("unexpected result: log_likelihood %0d", res.log_likelihood);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        if (res.log_likelihood !== want.ll) begin
          $error("log_likelihood expected %0d actual %0d", want.ll, res.log_likelihood);
          errors++;
        end
        if (res.likelihood_ratio !== want.lr) begin
          $error("likelihood_ratio expected %0d actual %0d", want.lr, res.likelihood_ratio);
          errors++;
        end
        if (res.invalid !== want.inv) begin
          $error("invalid expected %0b actual %0b", want.inv, res.invalid);
          errors++;
        end
        if (res.invalid === 1'b1) invalid_seen++;
      end
    end
  end

  initial begin
    window_row_t reset_rows [] = '{
      '{n: '0, u: '0, s: 2'd0, typed: 1'b1, want: ZERO_SCORE},
      '{n: '0, u: MEAS_TOP, s: 2'd3, typed: 1'b1, want: ZERO_SCORE},
      '{n: 24'd1, u: '0, s: 2'd1, typed: 1'b1, want: BAD_SCORE},
      '{n: CASES_TOP, u: MEAS_TOP, s: 2'd2, typed: 1'b1, want: BAD_SCORE}
    };
    window_row_t edge_rows [] = '{
      '{n: '0, u: 40'd500 << 16, s: 2'd0, typed: 1'b0, want: ZERO_SCORE},
      '{n: 24'd1000, u: 40'd500 << 16, s: 2'd0, typed: 1'b0, want: ZERO_SCORE},
      '{n: 24'd1000, u: 40'd1000 << 16, s: 2'd0, typed: 1'b0, want: ZERO_SCORE},
      '{n: 24'd1, u: 40'd1, s: 2'd0, typed: 1'b0, want: ZERO_SCORE},
      '{n: 24'd999, u: MEAS_W'((40'd1000 << 16) - 1), s: 2'd0, typed: 1'b0, want: ZERO_SCORE},
      '{n: 24'd1001, u: 40'd1, s: 2'd0, typed: 1'b1, want: BAD_SCORE},
      '{n: 24'd5, u: '0, s: 2'd0, typed: 1'b1, want: BAD_SCORE},
      '{n: 24'd10, u: 40'd1000 << 16, s: 2'd0, typed: 1'b1, want: BAD_SCORE},
      '{n: CASES_TOP, u: 40'd1, s: 2'd1, typed: 1'b0, want: ZERO_SCORE},
      '{n: 24'd1, u: MEAS_TOP - 1, s: 2'd1, typed: 1'b0, want: ZERO_SCORE},
      '{n: CASES_TOP - 1, u: MEAS_TOP - 1, s: 2'd1, typed: 1'b0, want: ZERO_SCORE},
      '{n: '0, u: MEAS_TOP, s: 2'd1, typed: 1'b1, want: BAD_SCORE},
      '{n: '0, u: '0, s: 2'd2, typed: 1'b1, want: ZERO_SCORE},
      '{n: '0, u: MEAS_TOP, s: 2'd2, typed: 1'b1, want: ZERO_SCORE},
      '{n: '0, u: '0, s: 2'd3, typed: 1'b1, want: BAD_SCORE},
      '{n: 24'd7, u: 40'd1, s: 2'd3, typed: 1'b1, want: BAD_SCORE}
    };
    logic [CASES_W-1:0] cases_cfg [SETS];
    logic [MEAS_W-1:0]  measure_cfg [SETS];
    int mode;

    win.valid = 1'b0;
    win.window_cases = '0;
    win.window_expected = '0;
    win.set_index = '0;
    for (int i = 0; i < SETS; i++) begin
      set_cases[i] = '0;
      set_measure[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (reset_rows[i]) send_window(reset_rows[i]);
    wait_idle();

    cases_cfg = '{24'd1000, CASES_TOP, 24'd0, 24'd7};
    measure_cfg = '{40'd1000 << 16, MEAS_TOP, 40'd5 << 16, 40'd0};
    load_totals(cases_cfg, measure_cfg);
    foreach (edge_rows[i]) send_window(edge_rows[i]);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < SETS; i++) begin
        mode = (phase == 1) ? i : $urandom_range(4);
        case (mode)
          0: begin
            cases_cfg[i] = CASES_TOP;
            measure_cfg[i] = MEAS_TOP;
          end
          1: begin
            cases_cfg[i] = '0;
            measure_cfg[i] = rand40();
          end
          2: begin
            cases_cfg[i] = CASES_W'($urandom_range(60));
            measure_cfg[i] = MEAS_W'($urandom_range(200, 1)) << FRAC;
          end
          3: begin
            cases_cfg[i] = CASES_TOP;
            measure_cfg[i] = MEAS_W'($urandom_range(3));
          end
          default: begin
            cases_cfg[i] = CASES_W'($urandom());
            measure_cfg[i] = rand40();
          end
        endcase
      end
      load_totals(cases_cfg, measure_cfg);
      no_idle = (phase == 2);
      for (int k = 0; k < 320; k++) begin
        if (phase == 3 && k == 20) hold_go = 1'b1;
        send_window(random_window());
      end
      wait_idle();
    end
    no_idle = 1'b0;

    $display("Sent %0d windows over 8 totals settings; %0d results checked, %0d flagged invalid.",
             windows_sent, scores_seen, invalid_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/psllr_pkg.sv
design/psllr_if.sv
design/psllr_front.sv
design/psllr_queue.sv
design/psllr_log2.sv
design/psllr_term.sv
design/psllr_back.sv
design/poisson_scan_log_likelihood_ratio.sv
bench/poisson_scan_log_likelihood_ratio_tb.sv
